// ===== rtl/wab_pkg.sv =====
// Package for the wrapping alpha-blend blit unit.
// Shared widths, codes, handshake structs and the divide-by-255 helper.
// No dependencies.
package wab_pkg;

  localparam int MAX_WIDTH_DEF  = 128;
  localparam int MAX_HEIGHT_DEF = 128;

  localparam int DIM_W       = 8;
  localparam int COORD_W     = 15;
  localparam int OFS_W       = 16;
  localparam int SUM_W       = 18;
  localparam int MAG_W       = 17;
  localparam int CNT_W       = $clog2(MAG_W);
  localparam int CHAN_W      = 8;
  localparam int OUT_COORD_W = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int PROD_W      = 2 * CHAN_W;

  localparam logic [CHAN_W-1:0] FULL = 8'd255;

  localparam logic [1:0] MODE_LOAD  = 2'd0;
  localparam logic [1:0] MODE_BLEND = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_DEST_WIDTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEST_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y    = 3'd3;

  localparam logic [1:0] CH_ALPHA = 2'd3;

  // byte 0 red, 1 green, 2 blue, 3 alpha
  typedef logic [3:0][CHAN_W-1:0] pixel_t;

  typedef struct packed {
    logic                    start;
    logic [SUM_W-1:0]        sum;
    logic [DIM_W-1:0]        modulus;
  } wrap_req_t;

  typedef struct packed {
    logic                    busy;
    logic                    done;
    logic [DIM_W-1:0]        result;
  } wrap_rsp_t;

  function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] p);
    logic [PROD_W:0] t;
    t = {1'b0, p} + (PROD_W+1)'(1) + {{(CHAN_W+1){1'b0}}, p[PROD_W-1:CHAN_W]};
    return t[PROD_W-1:CHAN_W];
  endfunction

endpackage

// ===== rtl/wab_wrap.sv =====
// Floor-modulo unit: one restoring-remainder bit per cycle, then sign fix-up.
// Used in turn for the x and the y axis. Depends on wab_pkg.
module wab_wrap (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  wab_pkg::wrap_req_t req_i,
  output wab_pkg::wrap_rsp_t rsp_o
);

  logic                          busy_q, fix_q, done_q;
  logic [wab_pkg::CNT_W-1:0]     cnt_q;
  logic [wab_pkg::MAG_W-1:0]     mag_q;
  logic [wab_pkg::DIM_W-1:0]     rem_q, mod_q, res_q;
  logic                          neg_q;

  logic [wab_pkg::SUM_W-1:0]     sum_abs;
  logic [wab_pkg::DIM_W:0]       trial, diff;
  logic                          ge;
  logic [wab_pkg::DIM_W-1:0]     rem_d;

  assign sum_abs = req_i.sum[wab_pkg::SUM_W-1] ? (~req_i.sum + wab_pkg::SUM_W'(1)) : req_i.sum;
  assign trial   = {rem_q, mag_q[wab_pkg::MAG_W-1]};
  assign diff    = trial - {1'b0, mod_q};
  assign ge      = trial >= {1'b0, mod_q};
  assign rem_d   = ge ? diff[wab_pkg::DIM_W-1:0] : trial[wab_pkg::DIM_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fix_q;
      fix_q  <= busy_q && (cnt_q == '0);
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= wab_pkg::CNT_W'(wab_pkg::MAG_W - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - wab_pkg::CNT_W'(1);
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.start) begin
      mag_q <= sum_abs[wab_pkg::MAG_W-1:0];
      neg_q <= req_i.sum[wab_pkg::SUM_W-1];
      mod_q <= req_i.modulus;
      rem_q <= '0;
    end else if (busy_q) begin
      mag_q <= {mag_q[wab_pkg::MAG_W-2:0], 1'b0};
      rem_q <= rem_d;
    end
    if (fix_q) begin
      res_q <= (neg_q && (rem_q != '0)) ? (mod_q - rem_q) : rem_q;
    end
  end

  assign rsp_o.busy   = busy_q | fix_q;
  assign rsp_o.done   = done_q;
  assign rsp_o.result = res_q;

  a_res_below_mod: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> (res_q < mod_q)) else $error("wrap result not below modulus");

  a_no_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.start |-> !(busy_q || fix_q)) else $error("wrap restarted while busy");

endmodule

// ===== rtl/wrapping_alpha_blend_blit_unit.sv =====
// Wrapping alpha-blend blit unit: frame store, sequencer, shared 8x8 multiplier.
// Depends on wab_pkg and wab_wrap.
//
//   channel | handshake               | payload
//   --------+-------------------------+-------------------------------------------
//   in      | in_valid_i / in_stall_o | mode, coord_x/y, pix_red/green/blue/alpha
//   out     | out_valid_o/out_stall_i | out_x/y, out_red/green/blue/alpha, error
//   cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// Load writes the store, read fetches from it and a rejected word goes straight to the
// output. Blend runs the bit-serial floor-modulo unit once per axis, then one store
// read, eight steps on the shared multiplier and one write-back. in_stall_o is high
// from accept until the result enters the output register. Reset sets the size to
// 128 x 128 and the offsets to 0; store contents stay undefined until loaded.
module wrapping_alpha_blend_blit_unit #(
  parameter int MAX_WIDTH  = wab_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = wab_pkg::MAX_HEIGHT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  logic [1:0]                         mode_i,
  input  logic [wab_pkg::COORD_W-1:0]        coord_x_i,
  input  logic [wab_pkg::COORD_W-1:0]        coord_y_i,
  input  logic [wab_pkg::CHAN_W-1:0]         pix_red_i,
  input  logic [wab_pkg::CHAN_W-1:0]         pix_green_i,
  input  logic [wab_pkg::CHAN_W-1:0]         pix_blue_i,
  input  logic [wab_pkg::CHAN_W-1:0]         pix_alpha_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output logic [wab_pkg::OUT_COORD_W-1:0]    out_x_o,
  output logic [wab_pkg::OUT_COORD_W-1:0]    out_y_o,
  output logic [wab_pkg::CHAN_W-1:0]         out_red_o,
  output logic [wab_pkg::CHAN_W-1:0]         out_green_o,
  output logic [wab_pkg::CHAN_W-1:0]         out_blue_o,
  output logic [wab_pkg::CHAN_W-1:0]         out_alpha_o,
  output logic                               out_range_error_o,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [wab_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [wab_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int XW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int YW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_LOAD  = 4'd1;
  localparam logic [3:0] S_RD1   = 4'd2;
  localparam logic [3:0] S_RD2   = 4'd3;
  localparam logic [3:0] S_WXS   = 4'd4;
  localparam logic [3:0] S_WX    = 4'd5;
  localparam logic [3:0] S_WYS   = 4'd6;
  localparam logic [3:0] S_WY    = 4'd7;
  localparam logic [3:0] S_FETCH = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_WB    = 4'd10;
  localparam logic [3:0] S_OUT   = 4'd11;

  logic [3:0]                      state_q, state_d;
  logic [wab_pkg::DIM_W-1:0]       dw_q, dh_q, eff_w, eff_h;
  logic [wab_pkg::OFS_W-1:0]       ofs_x_q, ofs_y_q;
  logic [wab_pkg::COORD_W-1:0]     cx_q, cy_q;
  logic [XW-1:0]                   x_q;
  logic [YW-1:0]                   y_q;
  wab_pkg::pixel_t                 src_q, acc_q, old_pix, in_pix;
  logic                            err_q;
  logic [2:0]                      step_q;
  logic [wab_pkg::PROD_W-1:0]      prod_q;
  logic [1:0]                      prod_ch_q;
  logic [31:0]                     rdata_q;
  logic [31:0]                     mem [DEPTH];
  logic [AW-1:0]                   addr;
  logic                            mem_we;

  logic                            in_acc, in_err, out_load;
  logic [wab_pkg::SUM_W-1:0]       sum_x, sum_y;
  wab_pkg::wrap_req_t              wreq;
  wab_pkg::wrap_rsp_t              wrsp;

  logic [1:0]                      ch;
  logic [wab_pkg::CHAN_W-1:0]      ia, mul_a, mul_b, quo;
  logic [wab_pkg::PROD_W-1:0]      prod;

  logic                            out_valid_q, out_err_q;
  logic [wab_pkg::OUT_COORD_W-1:0] out_x_q, out_y_q;
  wab_pkg::pixel_t                 out_pix_q;

  // configuration
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dw_q    <= wab_pkg::DIM_W'(128);
      dh_q    <= wab_pkg::DIM_W'(128);
      ofs_x_q <= '0;
      ofs_y_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        wab_pkg::REG_DEST_WIDTH:  dw_q    <= cfg_data_i[wab_pkg::DIM_W-1:0];
        wab_pkg::REG_DEST_HEIGHT: dh_q    <= cfg_data_i[wab_pkg::DIM_W-1:0];
        wab_pkg::REG_OFFSET_X:    ofs_x_q <= cfg_data_i;
        wab_pkg::REG_OFFSET_Y:    ofs_y_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (dw_q == '0) begin
      eff_w = wab_pkg::DIM_W'(1);
    end else if (32'(dw_q) > 32'(MAX_WIDTH)) begin
      eff_w = wab_pkg::DIM_W'(MAX_WIDTH);
    end else begin
      eff_w = dw_q;
    end
    if (dh_q == '0) begin
      eff_h = wab_pkg::DIM_W'(1);
    end else if (32'(dh_q) > 32'(MAX_HEIGHT)) begin
      eff_h = wab_pkg::DIM_W'(MAX_HEIGHT);
    end else begin
      eff_h = dh_q;
    end
  end

  // input decode
  assign in_stall_o = (state_q != S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_err     = (coord_x_i >= wab_pkg::COORD_W'(eff_w)) ||
                      (coord_y_i >= wab_pkg::COORD_W'(eff_h));
  assign in_pix     = {pix_alpha_i, pix_blue_i, pix_green_i, pix_red_i};

  // wrap unit
  assign sum_x = {{(wab_pkg::SUM_W-wab_pkg::COORD_W){1'b0}}, cx_q} +
                 {{(wab_pkg::SUM_W-wab_pkg::OFS_W){ofs_x_q[wab_pkg::OFS_W-1]}}, ofs_x_q};
  assign sum_y = {{(wab_pkg::SUM_W-wab_pkg::COORD_W){1'b0}}, cy_q} +
                 {{(wab_pkg::SUM_W-wab_pkg::OFS_W){ofs_y_q[wab_pkg::OFS_W-1]}}, ofs_y_q};

  assign wreq.start   = (state_q == S_WXS) || (state_q == S_WYS);
  assign wreq.sum     = (state_q == S_WYS) ? sum_y : sum_x;
  assign wreq.modulus = (state_q == S_WYS) ? eff_h : eff_w;

  wab_wrap u_wrap (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (wreq),
    .rsp_o  (wrsp)
  );

  // shared multiplier
  assign old_pix = wab_pkg::pixel_t'(rdata_q);
  assign ch      = step_q[2:1];
  assign ia      = wab_pkg::FULL - src_q[wab_pkg::CH_ALPHA];
  assign mul_a   = (step_q[0] || (ch == wab_pkg::CH_ALPHA)) ? old_pix[ch] : src_q[ch];
  assign mul_b   = (step_q[0] || (ch == wab_pkg::CH_ALPHA)) ? ia : src_q[wab_pkg::CH_ALPHA];
  assign prod    = {{wab_pkg::CHAN_W{1'b0}}, mul_a} * {{wab_pkg::CHAN_W{1'b0}}, mul_b};
  assign quo     = wab_pkg::div255(prod_q);

  // sequencer
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (mode_i == wab_pkg::MODE_BLEND) begin
            state_d = S_WXS;
          end else if ((mode_i == wab_pkg::MODE_LOAD) && !in_err) begin
            state_d = S_LOAD;
          end else if ((mode_i == wab_pkg::MODE_READ) && !in_err) begin
            state_d = S_RD1;
          end else begin
            state_d = S_OUT;
          end
        end
      end
      S_LOAD:  state_d = S_OUT;
      S_RD1:   state_d = S_RD2;
      S_RD2:   state_d = S_OUT;
      S_WXS:   state_d = S_WX;
      S_WX:    if (wrsp.done) state_d = S_WYS;
      S_WYS:   state_d = S_WY;
      S_WY:    if (wrsp.done) state_d = S_FETCH;
      S_FETCH: state_d = S_MUL;
      S_MUL:   if (step_q == 3'd7) state_d = S_WB;
      S_WB:    state_d = S_OUT;
      S_OUT:   if (out_load) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          cx_q  <= coord_x_i;
          cy_q  <= coord_y_i;
          src_q <= in_pix;
          if (((mode_i == wab_pkg::MODE_LOAD) || (mode_i == wab_pkg::MODE_READ)) && in_err ||
              !((mode_i == wab_pkg::MODE_LOAD) || (mode_i == wab_pkg::MODE_READ) ||
                (mode_i == wab_pkg::MODE_BLEND))) begin
            x_q   <= '0;
            y_q   <= '0;
            acc_q <= '0;
            err_q <= 1'b1;
          end else begin
            x_q   <= XW'(coord_x_i);
            y_q   <= YW'(coord_y_i);
            acc_q <= in_pix;
            err_q <= 1'b0;
          end
        end
      end
      S_RD2: acc_q <= old_pix;
      S_WX:  if (wrsp.done) x_q <= XW'(wrsp.result);
      S_WY:  if (wrsp.done) y_q <= YW'(wrsp.result);
      S_FETCH: begin
        step_q <= '0;
        acc_q  <= {src_q[wab_pkg::CH_ALPHA], {(3*wab_pkg::CHAN_W){1'b0}}};
      end
      S_MUL: begin
        prod_q    <= prod;
        prod_ch_q <= ch;
        step_q    <= step_q + 3'd1;
        if (step_q != '0) begin
          acc_q[prod_ch_q] <= acc_q[prod_ch_q] + quo;
        end
      end
      default: ;
    endcase
  end

  // frame store
  assign addr   = AW'(y_q) * AW'(MAX_WIDTH) + AW'(x_q);
  assign mem_we = (state_q == S_LOAD) || (state_q == S_WB);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[addr] <= acc_q;
    end
    rdata_q <= mem[addr];
  end

  // output register
  assign out_load = (state_q == S_OUT) && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_x_q   <= wab_pkg::OUT_COORD_W'(x_q);
      out_y_q   <= wab_pkg::OUT_COORD_W'(y_q);
      out_pix_q <= acc_q;
      out_err_q <= err_q;
    end
  end

  assign out_valid_o       = out_valid_q;
  assign out_x_o           = out_x_q;
  assign out_y_o           = out_y_q;
  assign out_red_o         = out_pix_q[0];
  assign out_green_o       = out_pix_q[1];
  assign out_blue_o        = out_pix_q[2];
  assign out_alpha_o       = out_pix_q[3];
  assign out_range_error_o = out_err_q;

  a_wrap_x_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WX && wrsp.done) |=> (32'(x_q) < 32'(eff_w)))
    else $error("wrapped x outside destination");

  a_acc_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL && step_q != '0) |->
      ((9'(acc_q[prod_ch_q]) + 9'(quo)) <= 9'(wab_pkg::FULL)))
    else $error("blend channel overflow");

  a_err_zero_payload: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_range_error_o) |->
      (out_x_o == '0 && out_y_o == '0 && out_pix_q == '0))
    else $error("rejected word carries payload");

endmodule
